// ----- rtl/cas_pkg.sv -----
package cas_pkg;

   // Fixed field widths of the configuration registers and the write port.
   localparam int GRID_WIDTH_W  = 11;
   localparam int GRID_HEIGHT_W = 13;
   localparam int LIMIT_W       = 4;
   localparam int CSR_DATA_W    = 13;
   localparam int CSR_INDEX_W   = 2;

   // Neighbor count and 3x3 window widths.
   localparam int COUNT_W = 4;
   localparam int WIN_W   = 9;

   // Register values after reset.
   localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RST     = 11'd64;
   localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RST    = 13'd64;
   localparam logic [LIMIT_W-1:0]       SURVIVAL_LIMIT_RST = 4'd4;
   localparam logic [LIMIT_W-1:0]       BIRTH_LIMIT_RST    = 4'd5;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_WIDTH     = 2'd0,
      CSR_GRID_HEIGHT    = 2'd1,
      CSR_SURVIVAL_LIMIT = 2'd2,
      CSR_BIRTH_LIMIT    = 2'd3
   } csr_index_type;

   // Per-cell control that the address stage hands to the stencil stage.
   typedef struct packed {
      logic wall_bit;    // incoming cell, forced to wall for flush beats
      logic have;        // this beat produces a result
      logic off_left;    // window column left of the center is off the map
      logic off_right;   // window column right of the center is off the map
      logic off_top;     // window row above the center is off the map
      logic off_bottom;  // window row below the center is off the map
      logic last;        // result is the final cell of the frame
      logic clear;       // window returns to zero after this beat
   } cas_slot_type;

endpackage

// ----- rtl/cas_ram.sv -----
module cas_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port; a read of the entry being
   // written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/cas_addr_gen.sv -----
module cas_addr_gen #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic                                kind,
   input  logic                                cell_is_wall,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]      eff_w,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]     eff_h,
   output logic [$clog2(MAX_WIDTH)-1:0]        rd_addr,
   output logic                                slot_valid,
   output cas_pkg::cas_slot_type               slot
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 3);

   logic [AW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic [AW-1:0] c;
   logic [AW-1:0] cc;
   logic [RW-1:0] cr;
   logic [RW-1:0] h_r;
   logic          flush;
   logic          ignore;
   logic          have;
   logic          row_wrap;
   logic [AW-1:0] col_nx;
   logic [RW-1:0] row_nx;
   logic          overflow;

   // Column clamped against the current width, then the window center it
   // completes: one column back, or the end of the row two rows up.
   always_comb begin
      h_r    = RW'(eff_h);
      c      = (WW'(col_ff) >= eff_w) ? AW'(eff_w - WW'(1)) : col_ff;
      flush  = kind || (row_ff >= h_r);
      ignore = kind && (row_ff == '0) && (col_ff == '0);
      if (c != '0) begin
         have = row_ff >= RW'(1);
         cr   = row_ff - RW'(1);
         cc   = c - AW'(1);
      end else begin
         have = row_ff >= RW'(2);
         cr   = row_ff - RW'(2);
         cc   = AW'(eff_w - WW'(1));
      end
      have = have && (cr < h_r);

      slot.wall_bit   = flush ? 1'b1 : cell_is_wall;
      slot.have       = have;
      slot.off_left   = cc == '0;
      slot.off_right  = (WW'(cc) + WW'(1)) == eff_w;
      slot.off_top    = cr == '0;
      slot.off_bottom = (cr + RW'(1)) == h_r;
      slot.last       = have && slot.off_bottom && slot.off_right;

      row_wrap = (WW'(c) + WW'(1)) >= eff_w;
      col_nx   = row_wrap ? '0 : c + AW'(1);
      row_nx   = row_wrap ? row_ff + RW'(1) : row_ff;
      overflow = row_nx > (h_r + RW'(1));
      slot.clear = slot.last || overflow;

      rd_addr    = c;
      slot_valid = !ignore;
   end

   // Next input position.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept && !ignore) begin
         if (slot.clear) begin
            col_in = '0;
            row_in = '0;
         end else begin
            col_in = col_nx;
            row_in = row_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ----- rtl/cas_stencil.sv -----
module cas_stencil #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 load,
   input  logic [$clog2(MAX_WIDTH)-1:0]         in_addr,
   input  cas_pkg::cas_slot_type                in_slot,
   input  logic [1:0]                           rd_data,
   input  logic [cas_pkg::LIMIT_W-1:0]          survival_limit,
   input  logic [cas_pkg::LIMIT_W-1:0]          birth_limit,
   output logic                                 wr_en,
   output logic [$clog2(MAX_WIDTH)-1:0]         wr_addr,
   output logic [1:0]                           wr_data,
   output logic                                 res_valid,
   output logic                                 res_next,
   output logic                                 res_last
);

   localparam int AW = $clog2(MAX_WIDTH);

   logic                               valid_ff;
   logic [AW-1:0]                      addr_ff;
   cas_pkg::cas_slot_type              slot_ff;
   logic                               fwd_ff;
   logic [1:0]                         fwd_data_ff;
   logic [cas_pkg::WIN_W-1:0]          window_ff, window_in;

   logic [1:0]                         stored;
   logic [2:0]                         col;
   logic [cas_pkg::WIN_W-1:0]          win_nx;
   logic [cas_pkg::COUNT_W-1:0]        cnt;
   logic                               off;

   // Stored column bits: bit 0 is two rows up, bit 1 one row up. A write to
   // the same entry in the cycle of the read is taken from the bypass.
   always_comb begin
      stored = fwd_ff ? fwd_data_ff : rd_data;
      col    = {slot_ff.wall_bit, stored[1], stored[0]};
      win_nx = {col, window_ff[cas_pkg::WIN_W-1:3]};
   end

   // Row stores shift down by one row at this column.
   assign wr_en   = valid_ff && advance;
   assign wr_addr = addr_ff;
   assign wr_data = {slot_ff.wall_bit, stored[1]};

   // Wall count over the eight neighbors, off-map positions counting as wall.
   always_comb begin
      cnt = '0;
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 3; j++) begin
            off = ((k == 0) && slot_ff.off_left) || ((k == 2) && slot_ff.off_right) ||
                  ((j == 0) && slot_ff.off_top) || ((j == 2) && slot_ff.off_bottom);
            if (!((k == 1) && (j == 1))) begin
               cnt = cnt + cas_pkg::COUNT_W'(off || win_nx[k*3+j]);
            end
         end
      end
   end

   assign res_valid = valid_ff && slot_ff.have;
   assign res_next  = win_nx[4] ? (cnt >= survival_limit) : (cnt >= birth_limit);
   assign res_last  = slot_ff.last;

   // Window moves on when the beat in this stage retires.
   always_comb begin
      window_in = window_ff;
      if (valid_ff && advance) begin
         window_in = slot_ff.clear ? '0 : win_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
         if (advance) begin
            valid_ff <= load;
         end
      end
   end

   // Beat capture, with the bypass armed when the retiring beat writes the
   // entry that the incoming beat reads.
   always_ff @(posedge clock) begin
      if (advance && load) begin
         addr_ff     <= in_addr;
         slot_ff     <= in_slot;
         fwd_ff      <= wr_en && (wr_addr == in_addr);
         fwd_data_ff <= wr_data;
      end
   end

endmodule

// ----- rtl/cave_automaton_step.sv -----
// Throughput: one beat per clock cycle while the output register is not
// stalled, set by the single read-modify-write of the row memory per cell.
// Result path: the beat that completes a window, grid_width+1 beats after
// its cell, passes the stencil stage register, then the output register.
// Reset clears the input position, the window, the pipeline and the output
// register and restores the register defaults; the row memory is not cleared.
module cave_automaton_step #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic                                 req_cell_is_wall,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_next_is_wall,
   output logic                                 rsp_last_of_frame,
   input  logic                                 csr_wr_en,
   input  logic [cas_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cas_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   logic [cas_pkg::GRID_WIDTH_W-1:0]  grid_width_ff;
   logic [cas_pkg::GRID_HEIGHT_W-1:0] grid_height_ff;
   logic [cas_pkg::LIMIT_W-1:0]       survival_limit_ff;
   logic [cas_pkg::LIMIT_W-1:0]       birth_limit_ff;

   logic [WW-1:0]          eff_w;
   logic [HW-1:0]          eff_h;
   logic                   accept;
   logic                   s1_adv;
   logic [AW-1:0]          mem_rd_addr;
   logic                   mem_rd_en;
   logic [1:0]             mem_rd_data;
   logic                   mem_wr_en;
   logic [AW-1:0]          mem_wr_addr;
   logic [1:0]             mem_wr_data;
   logic                   slot_valid;
   cas_pkg::cas_slot_type  slot;
   logic                   res_valid;
   logic                   res_next;
   logic                   res_last;
   logic                   rsp_valid_ff;
   logic                   rsp_next_ff;
   logic                   rsp_last_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff     <= cas_pkg::GRID_WIDTH_RST;
         grid_height_ff    <= cas_pkg::GRID_HEIGHT_RST;
         survival_limit_ff <= cas_pkg::SURVIVAL_LIMIT_RST;
         birth_limit_ff    <= cas_pkg::BIRTH_LIMIT_RST;
      end else if (csr_wr_en) begin
         unique case (cas_pkg::csr_index_type'(csr_index))
            cas_pkg::CSR_GRID_WIDTH: begin
               grid_width_ff <= csr_wdata[cas_pkg::GRID_WIDTH_W-1:0];
            end
            cas_pkg::CSR_GRID_HEIGHT: begin
               grid_height_ff <= csr_wdata[cas_pkg::GRID_HEIGHT_W-1:0];
            end
            cas_pkg::CSR_SURVIVAL_LIMIT: begin
               survival_limit_ff <= csr_wdata[cas_pkg::LIMIT_W-1:0];
            end
            cas_pkg::CSR_BIRTH_LIMIT: begin
               birth_limit_ff <= csr_wdata[cas_pkg::LIMIT_W-1:0];
            end
         endcase
      end
   end

   // Grid size in use: zero reads as one, oversize saturates.
   always_comb begin
      if (grid_width_ff == '0) begin
         eff_w = WW'(1);
      end else if (32'(grid_width_ff) > MAX_WIDTH) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(grid_width_ff);
      end
      if (grid_height_ff == '0) begin
         eff_h = HW'(1);
      end else if (32'(grid_height_ff) > MAX_HEIGHT) begin
         eff_h = HW'(MAX_HEIGHT);
      end else begin
         eff_h = HW'(grid_height_ff);
      end
   end

   // The stencil stage moves on unless its result is blocked by a full
   // output register that is not being drained.
   assign s1_adv    = !res_valid || !rsp_valid_ff || rsp_ready;
   assign req_ready = s1_adv;
   assign accept    = req_valid && req_ready;
   assign mem_rd_en = accept && slot_valid;

   cas_addr_gen #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_addr_gen (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .kind         (req_kind),
      .cell_is_wall (req_cell_is_wall),
      .eff_w        (eff_w),
      .eff_h        (eff_h),
      .rd_addr      (mem_rd_addr),
      .slot_valid   (slot_valid),
      .slot         (slot)
   );

   cas_ram #(
      .WIDTH (2),
      .DEPTH (MAX_WIDTH)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   cas_stencil #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_stencil (
      .clock          (clock),
      .reset          (reset),
      .advance        (s1_adv),
      .load           (mem_rd_en),
      .in_addr        (mem_rd_addr),
      .in_slot        (slot),
      .rd_data        (mem_rd_data),
      .survival_limit (survival_limit_ff),
      .birth_limit    (birth_limit_ff),
      .wr_en          (mem_wr_en),
      .wr_addr        (mem_wr_addr),
      .wr_data        (mem_wr_data),
      .res_valid      (res_valid),
      .res_next       (res_next),
      .res_last       (res_last)
   );

   // Output register for the result beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && s1_adv) begin
         rsp_next_ff <= res_next;
         rsp_last_ff <= res_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_is_wall  = rsp_next_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   // The row memory is only read inside the grid in use.
   a_rd_in_grid : assert property (@(posedge clock) disable iff (reset)
      mem_rd_en |-> (WW'(mem_rd_addr) < eff_w))
      else $error("row memory read beyond the grid width");

   // A beat that ends the frame shows up as a final result in the next cycle.
   a_last_follows : assert property (@(posedge clock) disable iff (reset)
      (accept && slot_valid && slot.last) |=> (res_valid && res_last))
      else $error("frame end beat did not produce a final result");

   // A waiting result is never overwritten by the stencil stage.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !(res_valid && s1_adv))
      else $error("result register overwritten while stalled");

endmodule

// ----- test/cave_automaton_step_tb.sv -----
`timescale 1ns / 100ps

module cave_automaton_step_tb;

   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 4096;
   localparam int RANDOM_BEATS = 520;
   localparam int SETTLE_CYCLES = 6;
   localparam int QUIET_LIMIT = 2000;

   // Beat kinds on the request channel.
   localparam bit KIND_CELL = 1'b0;
   localparam bit KIND_FLUSH = 1'b1;

   typedef struct packed {
      bit next_is_wall;
      bit last_of_frame;
   } cave_result_type;

   localparam cave_result_type NO_RESULT = '0;

   typedef enum bit {ROW_CSR, ROW_BEAT} row_op_type;

   typedef struct packed {
      row_op_type                       op;
      cas_pkg::csr_index_type           idx;
      logic [cas_pkg::CSR_DATA_W-1:0]   data;
      bit                               kind;
      bit                               wall;
      bit                               typed;
      cave_result_type                  res;
   } directed_row_type;

   typedef enum bit [1:0] {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_PERIODIC,
      READY_COIN
   } ready_pattern_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_kind = 1'b0;
   logic req_cell_is_wall = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_next_is_wall;
   logic rsp_last_of_frame;
   logic csr_wr_en = 1'b0;
   cas_pkg::csr_index_type csr_index = cas_pkg::CSR_GRID_WIDTH;
   logic [cas_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   cave_automaton_step #(
      .MAX_WIDTH  (MAX_COLS),
      .MAX_HEIGHT (MAX_ROWS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_cell_is_wall  (req_cell_is_wall),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_next_is_wall  (rsp_next_is_wall),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mirror of the block: registers, row stores, window and raster position.
   logic [cas_pkg::GRID_WIDTH_W-1:0]  cfg_width = cas_pkg::GRID_WIDTH_RST;
   logic [cas_pkg::GRID_HEIGHT_W-1:0] cfg_height = cas_pkg::GRID_HEIGHT_RST;
   logic [cas_pkg::LIMIT_W-1:0]       cfg_survive = cas_pkg::SURVIVAL_LIMIT_RST;
   logic [cas_pkg::LIMIT_W-1:0]       cfg_birth = cas_pkg::BIRTH_LIMIT_RST;
   bit older_row [MAX_COLS];
   bit newer_row [MAX_COLS];
   logic [cas_pkg::WIN_W-1:0] cave_window = '0;
   int col_pos = 0;
   int row_pos = 0;

   cave_result_type expected_cells [$];
   int errors = 0;
   int burst_left = 0;
   bit sender_steady = 1'b0;
   int random_beats = 0;
   int quiet_cycles = 0;

   // Appends one predicted result at the tail of the pending list.
   function automatic void queue_expected(input cave_result_type item);
      expected_cells.insert(expected_cells.size(), item);
   endfunction

   function automatic int eff_width();
      if (cfg_width == 0) return 1;
      return (cfg_width > MAX_COLS) ? MAX_COLS : int'(cfg_width);
   endfunction

   function automatic int eff_height();
      if (cfg_height == 0) return 1;
      return (cfg_height > MAX_ROWS) ? MAX_ROWS : int'(cfg_height);
   endfunction

   function automatic void clear_frame();
      cave_window = '0;
      col_pos = 0;
      row_pos = 0;
   endfunction

   // Takes one beat, returns 1 when it yields the next state of a delayed cell.
   function automatic bit advance_cave(input bit is_flush, input bit wall_in,
                                       output cave_result_type res);
      int w, h, c, r, cr, cc, cnt, k, j;
      bit cell_bit, have, off, center_bit;
      logic [2:0] triple;
      w = eff_width();
      h = eff_height();
      res = NO_RESULT;
      // A flush with no frame in progress changes nothing.
      if (is_flush && row_pos == 0 && col_pos == 0) return 1'b0;
      // Beats past the last row drain the frame whatever their kind.
      cell_bit = (is_flush || row_pos >= h) ? 1'b1 : wall_in;
      if (col_pos >= w) col_pos = w - 1;
      c = col_pos;
      r = row_pos;
      triple = {cell_bit, newer_row[c], older_row[c]};
      older_row[c] = newer_row[c];
      newer_row[c] = cell_bit;
      cave_window = {triple, cave_window[cas_pkg::WIN_W-1:3]};
      // Locate the window center; column zero closes the previous row.
      if (c >= 1) begin
         have = r >= 1;
         cr = r - 1;
         cc = c - 1;
      end else begin
         have = r >= 2;
         cr = r - 2;
         cc = w - 1;
      end
      have = have && (cr < h);
      if (have) begin
         cnt = 0;
         for (k = 0; k < 3; k++) begin
            for (j = 0; j < 3; j++) begin
               if (!(k == 1 && j == 1)) begin
                  off = (k == 0 && cc == 0) || (k == 2 && cc + 1 == w) ||
                        (j == 0 && cr == 0) || (j == 2 && cr + 1 == h);
                  cnt += off ? 1 : int'(cave_window[k*3+j]);
               end
            end
         end
         center_bit = cave_window[4];
         res.next_is_wall = center_bit ? (cnt >= int'(cfg_survive))
                                       : (cnt >= int'(cfg_birth));
         res.last_of_frame = (cr + 1 == h) && (cc + 1 == w);
         if (res.last_of_frame) begin
            clear_frame();
            return 1'b1;
         end
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = r + 1;
      end else begin
         col_pos = c + 1;
      end
      if (row_pos > h + 1) clear_frame();
      return have;
   endfunction

   function automatic directed_row_type csr_row(input cas_pkg::csr_index_type idx,
                                                input logic [cas_pkg::CSR_DATA_W-1:0] data);
      return '{ROW_CSR, idx, data, KIND_CELL, 1'b0, 1'b0, NO_RESULT};
   endfunction

   function automatic directed_row_type beat_row(input bit kind, input bit wall);
      return '{ROW_BEAT, cas_pkg::CSR_GRID_WIDTH, '0, kind, wall, 1'b0, NO_RESULT};
   endfunction

   function automatic directed_row_type beat_row_exp(input bit kind, input bit wall,
                                                     input bit nxt, input bit last);
      return '{ROW_BEAT, cas_pkg::CSR_GRID_WIDTH, '0, kind, wall, 1'b1, '{nxt, last}};
   endfunction

   function automatic logic [cas_pkg::LIMIT_W-1:0] pick_limit();
      if ($urandom_range(0, 5) == 0) return cas_pkg::LIMIT_W'($urandom_range(10, 15));
      return cas_pkg::LIMIT_W'($urandom_range(0, 9));
   endfunction

   // Sends one request beat; the sender runs in bursts split by random gaps.
   task automatic drive_beat(input bit kind_in, input bit wall_in, input bit typed,
                             input cave_result_type typed_res);
      int gap;
      cave_result_type res;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_kind <= kind_in;
      req_cell_is_wall <= wall_in;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      if (advance_cave(kind_in, wall_in, res))
         queue_expected(typed ? typed_res : res);
   endtask

   // Drops valid and waits until every pending result has come out.
   task automatic settle_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_cells.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_csr(input cas_pkg::csr_index_type idx,
                            input logic [cas_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         cas_pkg::CSR_GRID_WIDTH: cfg_width = data[cas_pkg::GRID_WIDTH_W-1:0];
         cas_pkg::CSR_GRID_HEIGHT: cfg_height = data[cas_pkg::GRID_HEIGHT_W-1:0];
         cas_pkg::CSR_SURVIVAL_LIMIT: cfg_survive = data[cas_pkg::LIMIT_W-1:0];
         cas_pkg::CSR_BIRTH_LIMIT: cfg_birth = data[cas_pkg::LIMIT_W-1:0];
      endcase
   endtask

   task automatic release_csr();
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // One whole frame of random cells, then the drain beats, some of them cells.
   task automatic stream_frame();
      int w, h, density, n;
      w = eff_width();
      h = eff_height();
      density = $urandom_range(0, 100);
      if ($urandom_range(0, 3) == 0)
         drive_beat(KIND_FLUSH, 1'($urandom_range(0, 1)), 1'b0, NO_RESULT);
      for (n = 0; n < w * h; n++)
         drive_beat(KIND_CELL, $urandom_range(0, 99) < density, 1'b0, NO_RESULT);
      for (n = 0; n <= w; n++)
         drive_beat(($urandom_range(0, 3) == 0) ? KIND_CELL : KIND_FLUSH,
                    1'($urandom_range(0, 1)), 1'b0, NO_RESULT);
      random_beats += w * h + w + 1;
   endtask

   task automatic run_phase(input logic [cas_pkg::GRID_WIDTH_W-1:0] w_raw,
                            input logic [cas_pkg::GRID_HEIGHT_W-1:0] h_raw,
                            input int frames);
      settle_pipeline();
      write_csr(cas_pkg::CSR_GRID_WIDTH, {2'($urandom_range(0, 3)), w_raw});
      write_csr(cas_pkg::CSR_GRID_HEIGHT, h_raw);
      write_csr(cas_pkg::CSR_SURVIVAL_LIMIT, {9'($urandom_range(0, 511)), pick_limit()});
      write_csr(cas_pkg::CSR_BIRTH_LIMIT, {9'($urandom_range(0, 511)), pick_limit()});
      release_csr();
      sender_steady = ($urandom_range(0, 4) == 0);
      repeat (frames) stream_frame();
   endtask

   // The receiver switches between several stall patterns of random length.
   ready_pattern_type ready_mode = READY_ALWAYS;
   int ready_span = 0;
   int ready_period = 2;
   int ready_tick = 0;

   always @(negedge clock) begin
      if (ready_span == 0) begin
         ready_mode = ready_pattern_type'($urandom_range(0, 3));
         ready_span = $urandom_range(16, 160);
         ready_period = $urandom_range(2, 8);
      end
      ready_span--;
      ready_tick++;
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_MOSTLY: rsp_ready <= ($urandom_range(0, 9) < 7);
         READY_PERIODIC: rsp_ready <= (ready_tick % ready_period) != 0;
         default: rsp_ready <= 1'($urandom_range(0, 1));
      endcase
   end

   // Each result beat is matched against the oldest pending cell.
   always @(posedge clock) begin : check_results
      cave_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cells.size() == 0) begin
            $error("result beat with no cell pending: next_is_wall=%0b last_of_frame=%0b",
                   rsp_next_is_wall, rsp_last_of_frame);
            errors++;
         end else begin
            want = expected_cells.pop_front();
            if (rsp_next_is_wall !== want.next_is_wall) begin
               $error("next_is_wall mismatch: expected %0b, actual %0b",
                      want.next_is_wall, rsp_next_is_wall);
               errors++;
            end
            if (rsp_last_of_frame !== want.last_of_frame) begin
               $error("last_of_frame mismatch: expected %0b, actual %0b",
                      want.last_of_frame, rsp_last_of_frame);
               errors++;
            end
         end
      end
   end

   // Ends the run when neither channel nor the register port moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("cave_automaton_step regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      directed_row_type directed_table [$];
      bit in_csr;
      logic [cas_pkg::GRID_WIDTH_W-1:0] w_raw;
      logic [cas_pkg::GRID_HEIGHT_W-1:0] h_raw;

      // Single-cell grids see all eight neighbors off the map; then a 2x2 grid
      // with both limits at zero turns every cell to wall.
      directed_table = '{
         csr_row(cas_pkg::CSR_GRID_WIDTH, 13'h1800),
         csr_row(cas_pkg::CSR_GRID_HEIGHT, 13'h0000),
         beat_row(KIND_FLUSH, 1'b1),
         beat_row(KIND_CELL, 1'b1),
         beat_row(KIND_FLUSH, 1'b0),
         beat_row_exp(KIND_FLUSH, 1'b0, 1'b1, 1'b1),
         beat_row(KIND_CELL, 1'b0),
         beat_row(KIND_CELL, 1'b0),
         beat_row_exp(KIND_CELL, 1'b1, 1'b1, 1'b1),
         csr_row(cas_pkg::CSR_SURVIVAL_LIMIT, 13'd9),
         csr_row(cas_pkg::CSR_BIRTH_LIMIT, 13'd8),
         beat_row(KIND_CELL, 1'b1),
         beat_row(KIND_FLUSH, 1'b1),
         beat_row_exp(KIND_FLUSH, 1'b1, 1'b0, 1'b1),
         beat_row(KIND_CELL, 1'b0),
         beat_row(KIND_FLUSH, 1'b0),
         beat_row_exp(KIND_FLUSH, 1'b0, 1'b1, 1'b1),
         csr_row(cas_pkg::CSR_GRID_WIDTH, 13'd2),
         csr_row(cas_pkg::CSR_GRID_HEIGHT, 13'd2),
         csr_row(cas_pkg::CSR_SURVIVAL_LIMIT, 13'd0),
         csr_row(cas_pkg::CSR_BIRTH_LIMIT, 13'd0),
         beat_row(KIND_CELL, 1'b1),
         beat_row(KIND_CELL, 1'b0),
         beat_row(KIND_CELL, 1'b0),
         beat_row_exp(KIND_CELL, 1'b1, 1'b1, 1'b0),
         beat_row_exp(KIND_FLUSH, 1'b0, 1'b1, 1'b0),
         beat_row_exp(KIND_FLUSH, 1'b1, 1'b1, 1'b0),
         beat_row_exp(KIND_FLUSH, 1'b0, 1'b1, 1'b1)
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows; register writes only once the block has drained.
      in_csr = 1'b0;
      foreach (directed_table[i]) begin
         if (directed_table[i].op == ROW_CSR) begin
            if (!in_csr) settle_pipeline();
            in_csr = 1'b1;
            write_csr(directed_table[i].idx, directed_table[i].data);
         end else begin
            if (in_csr) release_csr();
            in_csr = 1'b0;
            drive_beat(directed_table[i].kind, directed_table[i].wall,
                       directed_table[i].typed, directed_table[i].res);
         end
      end

      // A tall single column and a wide single row.
      run_phase(11'd1, 13'd40, 1);
      run_phase(11'd48, 13'd1, 1);

      // Mostly small random grids, now and then zero or wider ones.
      random_beats = 0;
      while (random_beats < RANDOM_BEATS) begin
         w_raw = ($urandom_range(0, 9) == 0)
                 ? cas_pkg::GRID_WIDTH_W'($urandom_range(0, 40))
                 : cas_pkg::GRID_WIDTH_W'($urandom_range(1, 10));
         h_raw = ($urandom_range(0, 9) == 0)
                 ? cas_pkg::GRID_HEIGHT_W'($urandom_range(0, 12))
                 : cas_pkg::GRID_HEIGHT_W'($urandom_range(1, 6));
         run_phase(w_raw, h_raw, $urandom_range(1, 3));
      end

      settle_pipeline();
      if (errors == 0)
         $display("cave_automaton_step regression: pass");
      else
         $display("cave_automaton_step regression: fail");
      $finish;
   end

endmodule

// ----- cave_automaton_step.f -----
rtl/cas_pkg.sv
rtl/cas_ram.sv
rtl/cas_addr_gen.sv
rtl/cas_stencil.sv
rtl/cave_automaton_step.sv
test/cave_automaton_step_tb.sv
